>>> src/u8s_pkg.sv
// shared types, constants and decode functions of the utf-8 sanitizer
`default_nettype none
package u8s_pkg;

   // replacement character U+FFFD as utf-8
   localparam logic [7:0] REPL_B0 = 8'hEF;
   localparam logic [7:0] REPL_B1 = 8'hBF;
   localparam logic [7:0] REPL_B2 = 8'hBD;

   // sub-byte indexes while sending a replacement
   localparam logic [1:0] SUB_FIRST = 2'd0;
   localparam logic [1:0] SUB_MID   = 2'd1;
   localparam logic [1:0] SUB_LAST  = 2'd2;

   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;

   // one classified request: up to four bytes, each passed or replaced
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [3:0]      repl;
      logic [1:0]      last;
      logic            str_end;
   } entry_type;

   // sequence length announced by a lead byte, 0 for an invalid lead
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (b < 8'h80) len = 3'd1;
      else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
      else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
      else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
      else len = 3'd0;
      return len;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b & CONT_MASK) == CONT_TAG;
   endfunction

endpackage
`default_nettype wire

>>> src/u8s_if.sv
// request and response channel interfaces of the utf-8 sanitizer
`default_nettype none
interface u8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_done;

   modport source (output valid, output out_byte, output run_last, output string_done,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input string_done,
                   output ready);
endinterface
`default_nettype wire

>>> src/u8s_front.sv
// front end: holds partial sequences and classifies each buffered byte
`default_nettype none
module u8s_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         in_byte,
   input  wire logic               string_end,
   output u8s_pkg::entry_type      entry,
   output logic                    push
);

   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];
   logic [1:0] held_ff, held_in;
   logic [2:0] exp_ff, exp_in;

   logic [3:0][7:0] buf_b;
   logic [2:0]      n_avail;
   logic [2:0]      new_len;
   logic            new_cont;
   logic [20:0]     code;
   logic            code_ok;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         buf_b[i] = (2'(i) < held_ff) ? pend_ff[i] : in_byte;
      end
      buf_b[3] = in_byte;
      n_avail  = {1'b0, held_ff} + 3'd1;
      new_len  = u8s_pkg::lead_length(in_byte);
      new_cont = u8s_pkg::is_cont(in_byte);
   end

   // code point of a complete held sequence
   always_comb begin
      unique case (exp_ff)
         3'd2:    code = {10'd0, buf_b[0][4:0], buf_b[1][5:0]};
         3'd3:    code = {5'd0, buf_b[0][3:0], buf_b[1][5:0], buf_b[2][5:0]};
         3'd4:    code = {buf_b[0][2:0], buf_b[1][5:0], buf_b[2][5:0], buf_b[3][5:0]};
         default: code = 21'd0;
      endcase
      code_ok = 1'b1;
      if (exp_ff == 3'd2 && code < 21'h80) code_ok = 1'b0;
      if (exp_ff == 3'd3 && code < 21'h800) code_ok = 1'b0;
      if (exp_ff == 3'd4 && code < 21'h10000) code_ok = 1'b0;
      if (code >= 21'hD800 && code <= 21'hDFFF) code_ok = 1'b0;
      if (code > 21'h10FFFF) code_ok = 1'b0;
   end

   always_comb begin
      entry.bytes   = buf_b;
      entry.repl    = 4'b0000;
      entry.last    = held_ff;
      entry.str_end = string_end;
      push          = 1'b0;
      held_in       = held_ff;
      exp_in        = exp_ff;
      for (int i = 0; i < 3; i++) pend_in[i] = pend_ff[i];

      if (held_ff == 2'd0 || !new_cont) begin
         // held lead (if any) is broken: replace it and its continuations
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_ff) entry.repl[i] = 1'b1;
         end
         if (new_len >= 3'd2 && !string_end) begin
            // new byte opens a sequence and waits
            held_in    = 2'd1;
            exp_in     = new_len;
            pend_in[0] = in_byte;
            entry.last = held_ff - 2'd1;
            push       = held_ff != 2'd0;
         end else begin
            entry.repl[held_ff] = new_len != 3'd1;
            held_in             = 2'd0;
            exp_in              = 3'd0;
            push                = 1'b1;
         end
      end else if (n_avail < exp_ff && !string_end) begin
         // good continuation, sequence still open
         held_in = held_ff + 2'd1;
         for (int i = 0; i < 3; i++) begin
            if (2'(i) == held_ff) pend_in[i] = in_byte;
         end
      end else begin
         // complete, or cut short by the string end
         held_in = 2'd0;
         exp_in  = 3'd0;
         push    = 1'b1;
         if (!(n_avail == exp_ff && code_ok)) entry.repl = 4'b1111;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         exp_ff  <= 3'd0;
      end else if (accept) begin
         held_ff <= held_in;
         exp_ff  <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) pend_ff[i] <= pend_in[i];
      end
   end

endmodule
`default_nettype wire

>>> src/u8s_fifo.sv
// short queue of classified entries between front and back
`default_nettype none
module u8s_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8s_pkg::entry_type wr_entry,
   input  wire logic               pop,
   output u8s_pkg::entry_type      rd_entry,
   output logic                    not_empty,
   output logic                    full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   u8s_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign not_empty = count_ff != CW'(0);
   assign full      = count_ff == CW'(DEPTH);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign rd_entry  = slot_ff[rd_ptr_ff];

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? PW'(0) : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (do_push && !do_pop) count_ff <= count_ff + CW'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wr_entry;
   end

endmodule
`default_nettype wire

>>> src/u8s_back.sv
// back end: expands queued entries into output bytes
`default_nettype none
module u8s_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire u8s_pkg::entry_type head,
   input  wire logic               head_valid,
   input  wire logic               rsp_ready,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic [7:0]              out_byte,
   output logic                    run_last,
   output logic                    string_done
);

   logic [1:0] pos_ff, pos_in;
   logic [1:0] sub_ff, sub_in;
   logic       tok_last, ent_last, fire;

   always_comb begin
      rsp_valid = head_valid;
      if (head.repl[pos_ff]) begin
         unique case (sub_ff)
            u8s_pkg::SUB_FIRST: out_byte = u8s_pkg::REPL_B0;
            u8s_pkg::SUB_MID:   out_byte = u8s_pkg::REPL_B1;
            default:            out_byte = u8s_pkg::REPL_B2;
         endcase
      end else begin
         out_byte = head.bytes[pos_ff];
      end
      tok_last    = !head.repl[pos_ff] || sub_ff == u8s_pkg::SUB_LAST;
      ent_last    = tok_last && pos_ff == head.last;
      run_last    = ent_last;
      string_done = ent_last && head.str_end;
      fire        = head_valid && rsp_ready;
      pop         = fire && ent_last;

      pos_in = pos_ff;
      sub_in = sub_ff;
      if (fire) begin
         if (!tok_last) begin
            sub_in = sub_ff + 2'd1;
         end else begin
            sub_in = u8s_pkg::SUB_FIRST;
            pos_in = ent_last ? 2'd0 : pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         sub_ff <= u8s_pkg::SUB_FIRST;
      end else begin
         pos_ff <= pos_in;
         sub_ff <= sub_in;
      end
   end

endmodule
`default_nettype wire

>>> src/utf8_sanitize_stream.sv
// top level of the streaming utf-8 sanitizer
//
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+-------------
//  req_chan | in  | in_byte[7:0], string_end             | valid/ready
//  rsp_chan | out | out_byte[7:0], run_last, string_done | valid/ready
//
// a request is taken while the queue has room; any bytes it yields are
// queued at that edge and offered from the queue behind earlier entries
// the back end sends one byte per cycle while the receiver is ready; a
// request yields 0 to 12 bytes (one per passed byte, three per replacement
// character) sent as one run; valid text also streams at that rate
// synchronous active-high reset empties the queue and drops held bytes
// a stalled response holds its byte; requests keep flowing until the queue
// fills, and a full queue drops ready even in a cycle that pops
`default_nettype none
module utf8_sanitize_stream #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   u8s_req_if.sink    req_chan,
   u8s_rsp_if.source  rsp_chan
);

   u8s_pkg::entry_type new_entry;
   u8s_pkg::entry_type head_entry;
   logic               req_fire;
   logic               push;
   logic               pop;
   logic               q_not_empty;
   logic               q_full;

   // request side stalls only when the queue is full
   assign req_chan.ready = !q_full;
   assign req_fire       = req_chan.valid && !q_full;

   // front: track open sequence and classify bytes
   u8s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .in_byte    (req_chan.in_byte),
      .string_end (req_chan.string_end),
      .entry      (new_entry),
      .push       (push)
   );

   // decoupling queue, push only on accepted requests that yield bytes
   u8s_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push && req_fire),
      .wr_entry  (new_entry),
      .pop       (pop),
      .rd_entry  (head_entry),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // back: serialize passed bytes and replacement characters
   u8s_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head_entry),
      .head_valid  (q_not_empty),
      .rsp_ready   (rsp_chan.ready),
      .pop         (pop),
      .rsp_valid   (rsp_chan.valid),
      .out_byte    (rsp_chan.out_byte),
      .run_last    (rsp_chan.run_last),
      .string_done (rsp_chan.string_done)
   );

endmodule
`default_nettype wire

>>> src/u8s_checker.sv
// port-level assertions for the utf-8 sanitizer, bound to the top level
`default_nettype none
module u8s_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] out_byte,
   input wire logic       run_last,
   input wire logic       string_done
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte)
         && $stable(run_last) && $stable(string_done))
      else $error("stalled response changed");

   // the end of a string always closes a request's output run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && string_done |-> run_last)
      else $error("string_done without run_last");

   // 0xEF inside a run opens a replacement or a three-byte character,
   // so a continuation-range byte follows right away
   a_repl_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && out_byte == u8s_pkg::REPL_B0 && !run_last
         |=> rsp_valid && (out_byte & u8s_pkg::CONT_MASK) == u8s_pkg::CONT_TAG)
      else $error("replacement sequence broken");

endmodule

bind utf8_sanitize_stream u8s_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .run_last    (rsp_chan.run_last),
   .string_done (rsp_chan.string_done)
);
`default_nettype wire

>>> dv/utf8_sanitize_stream_tb.sv
// self-checking testbench for the streaming utf-8 sanitizer
`timescale 1ns / 100ps
module utf8_sanitize_stream_tb;

   // pacing and run length
   localparam int ITEM_TARGET  = 420;   // request budget, the last string may run past it
   localparam int HOLD_AT      = 200;   // accepted requests before the long receiver hold
   localparam int HOLD_CYCLES  = 300;   // length of that hold
   localparam int DRAIN_AT     = 320;   // sent requests before the mid-run drain pause
   localparam int STALL_LIMIT  = 3000;  // cycles without any handshake before giving up
   localparam int TAIL_CYCLES  = 16;    // settle time once nothing is due
   localparam int SHOWN_ERRORS = 10;

   // one row of stimulus; n_exp > 0 means the expected bytes are typed in the row
   typedef struct packed {
      logic [7:0]  in_b;
      logic        fin;
      logic [1:0]  n_exp;
      logic [23:0] exp_bytes;   // first expected byte in the highest used lane
   } req_row_type;

   // one response byte with its flags
   typedef struct packed {
      logic [7:0] ob;
      logic       rl;
      logic       sd;
   } rsp_beat_type;

   // flaw classes used to break a character in the random part
   typedef enum int {
      BRK_NOISE, BRK_OVERLONG, BRK_SURROGATE, BRK_TOO_BIG,
      BRK_TRUNCATED, BRK_BAD_CONT, BRK_STRAY_CONT
   } flaw_type;

   // receiver back-pressure patterns, rotated through the run
   typedef enum int {RX_OPEN, RX_RANDOM, RX_MASK, RX_SPARSE} rx_mode_type;

   localparam logic [23:0] REPL_SEQ = {u8s_pkg::REPL_B0, u8s_pkg::REPL_B1, u8s_pkg::REPL_B2};

   logic clock = 1'b0;
   logic reset;

   u8s_req_if req_chan ();
   u8s_rsp_if rsp_chan ();

   utf8_sanitize_stream DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state: bytes of an unfinished sequence, oldest first
   logic [7:0] held_bytes [3];
   int         held_cnt;

   rsp_beat_type due_bytes [$];   // response bytes still owed, oldest first
   rsp_beat_type step_beats [$];  // bytes produced by the latest request
   req_row_type  offered [$];     // rows driven but not yet taken
   req_row_type  dir_tab [$];     // directed stimulus table
   logic [7:0]   str_q [$];       // random string under construction

   int req_count;
   int rsp_count;
   int strings_seen;
   int repl_count;
   int max_burst;
   int mismatch_count;
   int idle_cycles;
   int burst_left;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // length announced by a lead byte, 0 when it cannot start a sequence
   function automatic int seq_len(input logic [7:0] b);
      if (!b[7]) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   function automatic logic [20:0] lead_bits(input logic [7:0] b);
      case (seq_len(b))
         2: return {16'd0, b[4:0]};
         3: return {17'd0, b[3:0]};
         4: return {18'd0, b[2:0]};
         default: return 21'd0;
      endcase
   endfunction

   // rejects overlong forms, surrogates and values past the last plane
   function automatic logic cp_legal(input int len, input logic [20:0] cp);
      if (len == 2 && cp < 21'h80) return 1'b0;
      if (len == 3 && cp < 21'h800) return 1'b0;
      if (len == 4 && cp < 21'h10000) return 1'b0;
      if (cp >= 21'hD800 && cp <= 21'hDFFF) return 1'b0;
      if (cp > 21'h10FFFF) return 1'b0;
      return 1'b1;
   endfunction

   // advance the predictor by one request and leave its output in step_beats
   task automatic sanitize_step(input logic [7:0] b, input logic fin);
      logic [7:0]  seq [4];
      logic [7:0]  em [12];
      logic [20:0] cp;
      logic        bad, waiting;
      int          n, p, k, j, len, avail;
      n = 0;
      for (j = 0; j < held_cnt; j++) begin
         seq[n] = held_bytes[j];
         n++;
      end
      seq[n] = b;
      n++;
      p = 0;
      k = 0;
      waiting = 1'b0;
      while (p < n && !waiting) begin
         len   = seq_len(seq[p]);
         avail = n - p;
         bad   = 1'b0;
         cp    = lead_bits(seq[p]);
         if (len == 1) begin
            em[k] = seq[p];
            k++;
            p++;
         end else begin
            if (len != 0) begin
               for (j = 1; j < len && j < avail && !bad; j++) begin
                  if (seq[p+j][7:6] != 2'b10) bad = 1'b1;
                  else cp = {cp[14:0], seq[p+j][5:0]};
               end
            end
            if (len != 0 && !bad && avail < len && !fin) begin
               // sequence still open, hold it
               waiting = 1'b1;
            end else if (len != 0 && !bad && avail >= len && cp_legal(len, cp)) begin
               for (j = 0; j < len; j++) begin
                  em[k] = seq[p+j];
                  k++;
               end
               p += len;
            end else begin
               // replace the lead only, rescan what follows it
               em[k]   = u8s_pkg::REPL_B0;
               em[k+1] = u8s_pkg::REPL_B1;
               em[k+2] = u8s_pkg::REPL_B2;
               k += 3;
               p++;
               repl_count++;
            end
         end
      end
      held_cnt = 0;
      for (j = p; j < n && held_cnt < 3; j++) begin
         held_bytes[held_cnt] = seq[j];
         held_cnt++;
      end
      step_beats.delete();
      for (j = 0; j < k; j++)
         step_beats.insert(step_beats.size(), {em[j], j == k - 1, (j == k - 1) && fin});
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input rsp_beat_type want,
                                input rsp_beat_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
         $display("%0t mismatch, %s: expected byte/last/done %h/%b/%b, got %h/%b/%b",
                  $time, what, want.ob, want.rl, want.sd, got.ob, got.rl, got.sd);
   endtask

   task automatic take_request();
      req_row_type row;
      int          i;
      row = offered.pop_front();
      sanitize_step(req_chan.in_byte, req_chan.string_end);
      if (row.n_exp != 0) begin
         // typed row: expected bytes come from the table, predictor only tracks state
         for (i = 0; i < row.n_exp; i++)
            due_bytes.insert(due_bytes.size(),
                             {row.exp_bytes[8*(row.n_exp-1-i) +: 8], i == row.n_exp - 1,
                              (i == row.n_exp - 1) && row.fin});
      end else begin
         foreach (step_beats[i]) due_bytes.insert(due_bytes.size(), step_beats[i]);
      end
      if (step_beats.size() > max_burst) max_burst = step_beats.size();
      if (req_chan.string_end) strings_seen++;
      req_count++;
   endtask

   task automatic take_response();
      rsp_beat_type got, want;
      got = {rsp_chan.out_byte, rsp_chan.run_last, rsp_chan.string_done};
      rsp_count++;
      if (due_bytes.size() == 0) begin
         flag_mismatch("no byte owed", '0, got);
      end else begin
         want = due_bytes.pop_front();
         if (want.ob !== got.ob || want.rl !== got.rl || want.sd !== got.sd)
            flag_mismatch($sformatf("response %0d", rsp_count), want, got);
      end
   endtask

   // sample both channels at the rising edge, requests first; a response never
   // comes from a request taken at the same edge, as bytes pass the queue
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) take_request();
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) take_response();
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d bytes still owed",
                     STALL_LIMIT, due_bytes.size());
            $display("[utf8_sanitize_stream] ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: rotating stall patterns plus one long hold-off
   // ------------------------------------------------------------------
   initial begin
      int          cyc;
      int          hold_left;
      logic        hold_done;
      logic [7:0]  mask;
      rx_mode_type mode;
      cyc = 0;
      hold_left = 0;
      hold_done = 1'b0;
      mask = 8'b1101_0110;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cyc++;
         // one long hold so the block fills up and pushes back on requests
         if (!hold_done && req_count >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         mask = {mask[6:0], mask[7]};
         mode = rx_mode_type'((cyc / 96) % 4);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:   rsp_chan.ready <= 1'b1;
               RX_RANDOM: rsp_chan.ready <= ($urandom_range(0, 2) != 0);
               RX_MASK:   rsp_chan.ready <= mask[0];
               default:   rsp_chan.ready <= ($urandom_range(0, 5) != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------

   task automatic idle_gap(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
   endtask

   // offer one request, hold it until taken, then maybe end the burst
   task automatic send_row(input req_row_type row);
      offered.insert(offered.size(), row);
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.in_byte    <= row.in_b;
      req_chan.string_end <= row.fin;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         idle_gap($urandom_range(1, 6));
         // mostly short bursts, now and then a long unbroken run
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // stop offering until every owed byte has come back
   task automatic drain_pause();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_bytes.size() != 0 || offered.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [7:0] b, input logic fin, input logic [1:0] n,
                          input logic [23:0] exp);
      dir_tab.insert(dir_tab.size(), {b, fin, n, exp});
   endtask

   // append one byte to the string under construction
   task automatic add_byte(input logic [7:0] v);
      str_q.insert(str_q.size(), v);
   endtask

   // append a code point to the string in the given encoding length
   task automatic put_cp(input logic [20:0] cp, input int len);
      case (len)
         1: add_byte({1'b0, cp[6:0]});
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   function automatic int cp_len(input logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   // random well-formed code point of the given multi-byte length
   function automatic logic [20:0] random_legal(input int len);
      logic [20:0] cp;
      case (len)
         2: cp = 21'($urandom_range(21'h80, 21'h7FF));
         3: begin
            cp = 21'($urandom_range(21'h800, 21'hF7FF));
            if (cp >= 21'hD800) cp = cp + 21'h800;   // step over the surrogates
         end
         default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
      return cp;
   endfunction

   // one random string: mostly well-formed characters, some noise and broken ones
   task automatic build_string();
      int          chars, c, pick, len, base, drop;
      logic [20:0] cp;
      logic [7:0]  bv;
      flaw_type    flaw;
      str_q.delete();
      chars = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
      for (c = 0; c < chars; c++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            bv = 8'($urandom_range(0, 127));
            add_byte(bv);
         end else if (pick < 72) begin
            len = $urandom_range(2, 4);
            put_cp(random_legal(len), len);
         end else if (pick < 78) begin
            // code points on the edges of each length and of the surrogate gap
            case ($urandom_range(0, 10))
               0: cp = 21'h0;
               1: cp = 21'h7F;
               2: cp = 21'h80;
               3: cp = 21'h7FF;
               4: cp = 21'h800;
               5: cp = 21'hD7FF;
               6: cp = 21'hE000;
               7: cp = 21'hFFFD;
               8: cp = 21'hFFFF;
               9: cp = 21'h10000;
               default: cp = 21'h10FFFF;
            endcase
            put_cp(cp, cp_len(cp));
         end else begin
            flaw = flaw_type'($urandom_range(0, 6));
            case (flaw)
               BRK_NOISE: begin
                  bv = 8'($urandom_range(0, 255));
                  add_byte(bv);
               end
               BRK_OVERLONG: begin
                  len = $urandom_range(2, 4);
                  if (len == 2) cp = 21'($urandom_range(0, 21'h7F));
                  else if (len == 3) cp = 21'($urandom_range(0, 21'h7FF));
                  else cp = 21'($urandom_range(0, 21'hFFFF));
                  put_cp(cp, len);
               end
               BRK_SURROGATE: put_cp(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
               BRK_TOO_BIG:   put_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
               BRK_TRUNCATED: begin
                  len = $urandom_range(2, 4);
                  put_cp(random_legal(len), len);
                  drop = $urandom_range(1, len - 1);
                  repeat (drop) bv = str_q.pop_back();
               end
               BRK_BAD_CONT: begin
                  len  = $urandom_range(2, 4);
                  base = str_q.size();
                  put_cp(random_legal(len), len);
                  if ($urandom_range(0, 1) == 0) bv = 8'($urandom_range(0, 8'h7F));
                  else bv = 8'($urandom_range(8'hC0, 8'hFF));
                  str_q[base + $urandom_range(1, len - 1)] = bv;
               end
               default: begin
                  bv = 8'($urandom_range(8'h80, 8'hBF));
                  add_byte(bv);
               end
            endcase
         end
      end
   endtask

   initial begin
      req_row_type row;
      int          sent, i;
      logic        drained_mid;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.in_byte    = 8'h00;
      req_chan.string_end = 1'b0;
      held_cnt       = 0;
      req_count      = 0;
      rsp_count      = 0;
      strings_seen   = 0;
      repl_count     = 0;
      max_burst      = 0;
      mismatch_count = 0;
      idle_cycles    = 0;
      burst_left     = $urandom_range(1, 12);
      drained_mid    = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: typed rows are plain reads, the rest go to the predictor
      add_row(8'h7F, 1'b0, 2'd1, 24'h00007F);   // largest ascii right after reset
      add_row(8'h00, 1'b1, 2'd1, 24'h000000);   // smallest byte ends a string
      add_row(8'hFF, 1'b1, 2'd3, REPL_SEQ);     // all-ones byte is never a lead
      add_row(8'h80, 1'b0, 2'd3, REPL_SEQ);     // lone continuation byte
      add_row(8'hF8, 1'b0, 2'd3, REPL_SEQ);     // five-byte style lead
      add_row(8'hC3, 1'b0, 2'd0, 24'h0);        // two-byte, held with no output
      add_row(8'hA9, 1'b0, 2'd0, 24'h0);
      add_row(8'hC1, 1'b0, 2'd0, 24'h0);        // overlong two-byte form
      add_row(8'h80, 1'b0, 2'd0, 24'h0);
      add_row(8'hE2, 1'b0, 2'd0, 24'h0);        // three-byte euro sign
      add_row(8'h82, 1'b0, 2'd0, 24'h0);
      add_row(8'hAC, 1'b0, 2'd0, 24'h0);
      add_row(8'hED, 1'b0, 2'd0, 24'h0);        // first surrogate
      add_row(8'hA0, 1'b0, 2'd0, 24'h0);
      add_row(8'h80, 1'b0, 2'd0, 24'h0);
      add_row(8'hF0, 1'b0, 2'd0, 24'h0);        // four-byte character
      add_row(8'h9F, 1'b0, 2'd0, 24'h0);
      add_row(8'h98, 1'b0, 2'd0, 24'h0);
      add_row(8'h80, 1'b0, 2'd0, 24'h0);
      add_row(8'hF4, 1'b0, 2'd0, 24'h0);        // past the last plane, longest burst
      add_row(8'h90, 1'b0, 2'd0, 24'h0);
      add_row(8'h80, 1'b0, 2'd0, 24'h0);
      add_row(8'h80, 1'b0, 2'd0, 24'h0);
      add_row(8'hE2, 1'b0, 2'd0, 24'h0);        // continuation replaced by ascii
      add_row(8'h41, 1'b0, 2'd0, 24'h0);
      add_row(8'hF0, 1'b0, 2'd0, 24'h0);        // sequence cut short by string end
      add_row(8'h9F, 1'b1, 2'd0, 24'h0);

      foreach (dir_tab[i]) send_row(dir_tab[i]);
      sent = dir_tab.size();
      drain_pause();

      // random strings until the request budget is spent
      while (sent < ITEM_TARGET) begin
         build_string();
         for (i = 0; i < str_q.size(); i++) begin
            row = {str_q[i], i == str_q.size() - 1, 2'd0, 24'h0};
            send_row(row);
            sent++;
         end
         if (!drained_mid && sent >= DRAIN_AT) begin
            drain_pause();
            drained_mid = 1'b1;
         end
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d requests in %0d strings, %0d response bytes checked",
               req_count, strings_seen, rsp_count);
      $display("%0d replacement characters, up to %0d bytes from one request, %0d mismatches",
               repl_count, max_burst, mismatch_count);
      if (mismatch_count == 0)
         $display("[utf8_sanitize_stream] OK");
      else
         $display("[utf8_sanitize_stream] ERROR");
      $finish;
   end

endmodule

>>> sim.f
src/u8s_pkg.sv
src/u8s_if.sv
src/u8s_front.sv
src/u8s_fifo.sv
src/u8s_back.sv
src/utf8_sanitize_stream.sv
src/u8s_checker.sv
dv/utf8_sanitize_stream_tb.sv
